FILE: src/mcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcrc_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT = 2'd2;

  localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] MASK_RESET = 32'hD202_EF8D;
  localparam logic [CRC_W-1:0] INIT_RESET = 32'h0000_0000;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [CRC_W-1:0] remainder;
    logic             done_res;
  } out_t;

  typedef struct packed {
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] byte_mask;
    logic [CRC_W-1:0] initial_value;
  } cfg_t;

endpackage
`default_nettype wire

FILE: src/mcrc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module mcrc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mcrc_pkg::CRC_W-1:0]       cfg_wdata,
  output mcrc_pkg::cfg_t                        cfg
);

  mcrc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.polynomial    <= mcrc_pkg::POLY_RESET;
      regs.byte_mask     <= mcrc_pkg::MASK_RESET;
      regs.initial_value <= mcrc_pkg::INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcrc_pkg::REG_POLY: regs.polynomial    <= cfg_wdata;
        mcrc_pkg::REG_MASK: regs.byte_mask     <= cfg_wdata;
        mcrc_pkg::REG_INIT: regs.initial_value <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

FILE: src/mcrc_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// Unrolled eight-bit reflected fold followed by the mask.
module mcrc_fold (
  input  wire logic [mcrc_pkg::CRC_W-1:0]  rem_in,
  input  wire logic [mcrc_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [mcrc_pkg::CRC_W-1:0]  polynomial,
  input  wire logic [mcrc_pkg::CRC_W-1:0]  byte_mask,
  output logic      [mcrc_pkg::CRC_W-1:0]  rem_out
);

  logic [mcrc_pkg::CRC_W-1:0] r;

  always_comb begin
    r = rem_in ^ {{(mcrc_pkg::CRC_W-mcrc_pkg::BYTE_W){1'b0}}, data_byte};
    for (int k = 0; k < mcrc_pkg::BYTE_W; k++) begin
      r = (r >> 1) ^ (r[0] ? polynomial : '0);
    end
    rem_out = r ^ byte_mask;
  end

endmodule
`default_nettype wire

FILE: src/masked_crc32_byte_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Masked reflected CRC-32 engine, one byte per beat. Each accepted beat carries a data
// byte plus first/last flags; first reloads initial_value before the fold, the byte is
// folded through the reflected polynomial over eight unrolled bit steps, byte_mask is
// XORed in, and the result beat gives the new remainder with done_res echoing last.
// Throughput is one byte per clock while output beats are taken: an input register
// feeds the fold, whose result lands in the output register and the running remainder
// in the same edge, so the remainder loop passes through a single register. A beat
// held in the input register is offered as a result once it moves to the output
// register. Both stages stall only when the output beat is not taken. Registers are
// written through the plain write port (0 polynomial, 1 byte_mask, 2 initial_value,
// other indexes ignored) and should only be changed while no beat is in flight.
module masked_crc32_byte_engine_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mcrc_pkg::CRC_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire mcrc_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mcrc_pkg::out_t                        out_data
);

  mcrc_pkg::cfg_t cfg;

  // input stage
  logic          in_full;
  mcrc_pkg::in_t in_reg;

  // output stage and running remainder
  logic                        out_full;
  mcrc_pkg::out_t              out_reg;
  logic [mcrc_pkg::CRC_W-1:0]  crc_rem;

  logic [mcrc_pkg::CRC_W-1:0]  fold_base;
  logic [mcrc_pkg::CRC_W-1:0]  fold_res;
  logic                        advance;

  mcrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // first byte starts from the initial value, otherwise carry on
  assign fold_base = in_reg.first_byte ? cfg.initial_value : crc_rem;

  mcrc_fold u_fold (
    .rem_in     (fold_base),
    .data_byte  (in_reg.data_byte),
    .polynomial (cfg.polynomial),
    .byte_mask  (cfg.byte_mask),
    .rem_out    (fold_res)
  );

  // move the held byte into the output slot when that slot is free or draining
  assign advance  = in_full && (!out_full || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      crc_rem  <= mcrc_pkg::INIT_RESET;
    end else begin
      if (advance) begin
        out_full <= 1'b1;
        crc_rem  <= fold_res;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg.remainder <= fold_res;
      out_reg.done_res  <= in_reg.last_byte;
    end
  end

  assign out_valid = out_full;
  assign out_data  = out_reg;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_full && crc_rem == mcrc_pkg::INIT_RESET)
    else $error("reset did not clear pipeline state");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat missing at output");

  a_rem_tracks_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> crc_rem == out_data.remainder)
    else $error("running remainder differs from emitted remainder");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_full && !out_ready)
    else $error("input stalled without a blocked output");

  a_rem_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(crc_rem))
    else $error("remainder changed without a beat");
`endif

endmodule
`default_nettype wire
